>>> rtl/b64d_pkg.sv
// shared types, constants and the character decode function of the base64 decoder
// no dependencies; imported by every other module of the block
package b64d_pkg;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CHAR   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // one decoded group handed from the front to the back
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;
      status_type  status;
      logic        eom;
   } job_type;

   localparam int JOB_WIDTH = $bits(job_type);

   typedef struct packed {
      logic       valid;
      logic [5:0] sextet;
   } sextet_type;

   function automatic sextet_type char_to_sextet(input logic [7:0] c);
      sextet_type r;
      r.valid  = 1'b1;
      r.sextet = 6'd0;
      case (c) inside
         [8'h41:8'h5A]: r.sextet = 6'(c - 8'h41);
         [8'h61:8'h7A]: r.sextet = 6'(c - 8'h61 + 8'd26);
         [8'h30:8'h39]: r.sextet = 6'(c - 8'h30 + 8'd52);
         8'h2B:         r.sextet = 6'd62;
         8'h2F:         r.sextet = 6'd63;
         PAD_CHAR:      r.sextet = 6'd0;
         default:       r.valid  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/b64d_front.sv
// front end: takes characters, gathers sextets and classifies each finished group
// depends on b64d_pkg; pushes one job per group or error into the queue
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       last_char,
   output logic       push,
   output job_type    job
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic        third_ff, third_in;
   logic        disc_ff, disc_in;

   sextet_type dec;
   logic       is_pad;
   logic [1:0] count;

   assign dec    = char_to_sextet(char_code);
   assign is_pad = (char_code == PAD_CHAR);

   always_comb begin
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      bad_in   = bad_ff;
      third_in = third_ff;
      disc_in  = disc_ff;
      push     = 1'b0;
      job      = '{triple: 24'd0, count: 2'd1, status: STATUS_OK, eom: 1'b1};
      count    = 2'd3 - {1'b0, last_char & is_pad} - {1'b0, last_char & third_ff};
      if (accept) begin
         if (disc_ff) begin
            if (last_char) begin
               pos_in   = 2'd0;
               acc_in   = 18'd0;
               bad_in   = 1'b0;
               third_in = 1'b0;
               disc_in  = 1'b0;
            end
         end else if (pos_ff != 2'd3) begin
            if (last_char) begin
               push       = 1'b1;
               job.status = STATUS_BAD_LENGTH;
               pos_in     = 2'd0;
               acc_in     = 18'd0;
               bad_in     = 1'b0;
               third_in   = 1'b0;
            end else begin
               acc_in = {acc_ff[11:0], dec.sextet};
               bad_in = bad_ff | ~dec.valid;
               if (pos_ff == 2'd2) begin
                  third_in = is_pad;
               end
               pos_in = pos_ff + 2'd1;
            end
         end else begin
            push = 1'b1;
            if (bad_ff || !dec.valid) begin
               job.status = STATUS_BAD_CHAR;
               disc_in    = ~last_char;
            end else begin
               job.triple = {acc_ff, dec.sextet};
               job.count  = count;
               job.eom    = last_char;
            end
            pos_in   = 2'd0;
            acc_in   = 18'd0;
            bad_in   = 1'b0;
            third_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         acc_ff   <= 18'd0;
         bad_ff   <= 1'b0;
         third_ff <= 1'b0;
         disc_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         bad_ff   <= bad_in;
         third_ff <= third_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

>>> rtl/b64d_queue.sv
// short register queue of decoded jobs between front and back
// depends on b64d_pkg for the entry width only
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [JOB_WIDTH-1:0] push_data,
   input  logic                 pop,
   output logic [JOB_WIDTH-1:0] pop_data,
   output logic                 full,
   output logic                 not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [JOB_WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/b64d_back.sv
// back end: takes one job from the queue and sends its bytes one per transaction
// depends on b64d_pkg; results are selected combinationally from the registered job
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_eom
);

   job_type    job_ff, job_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       fire;
   logic       last_idx;
   logic       load;

   assign fire     = busy_ff & rsp_ready;
   assign last_idx = (idx_ff == job_ff.count - 2'd1);
   assign load     = q_valid & (~busy_ff | (fire & last_idx));
   assign pop      = load;

   always_comb begin
      job_in  = job_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         job_in  = q_job;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
         if (last_idx) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_byte = job_ff.triple[23:16];
         2'd1:    rsp_byte = job_ff.triple[15:8];
         2'd2:    rsp_byte = job_ff.triple[7:0];
         default: rsp_byte = 8'd0;
      endcase
   end

   assign rsp_valid  = busy_ff;
   assign rsp_status = job_ff.status;
   assign rsp_eom    = job_ff.eom & last_idx;

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> rtl/base64_stream_decoder_top.sv
// streaming base64 decoder, one character per transaction in, one byte per transaction out
// a group's result is written into the job queue in the transaction that takes its last character
// and is offered once the back end has loaded it from the queue into its job register
// throughput: one character per cycle until the queue fills and req_tready drops; one result
// per cycle while rsp_tready is high, the job queue absorbing groups while the result side stalls
// reset: synchronous, clears group state, queue and output; no clearing pass
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast
);

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   job_type push_job;
   job_type pop_job;

   assign req_tready = ~full;
   assign accept     = req_tvalid & req_tready;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_tdata),
      .last_char (req_tlast),
      .push      (push),
      .job       (push_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .full      (full),
      .not_empty (not_empty)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (not_empty),
      .q_job      (pop_job),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_status (rsp_tuser),
      .rsp_eom    (rsp_tlast)
   );

   // an error result is always alone and ends the message
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("error result without end of message or with data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_BAD_CHAR ||
                      rsp_tuser == STATUS_BAD_LENGTH))
      else $error("undefined status code");

   // queue never overflows or underflows
   assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && !not_empty))
      else $error("job queue overflow or underflow");

   // a stalled result stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result dropped or changed by back end");

endmodule
